// ===== sv/mkds_pkg.sv =====
package mkds_pkg;

    localparam int NUM_ROWS    = 4;
    localparam int NUM_COLUMNS = 4;
    localparam int TIMER_BITS  = 16;

    localparam int ROW_BITS   = $clog2(NUM_ROWS);
    localparam int COL_BITS   = $clog2(NUM_COLUMNS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = {{(TIMER_BITS-1){1'b0}}, 1'b1};

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_EVENT_EN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_EVENT_EN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_EVENT_EN    = 3'd4;

    localparam logic [15:0] DEBOUNCE_TICKS_RESET   = 16'd60;
    localparam logic [15:0] LONG_PRESS_TICKS_RESET = 16'd300;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2,
        EV_LONG    = 2'd3
    } event_t;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] long_press_ticks;
        logic        press_event_enable;
        logic        release_event_enable;
        logic        long_event_enable;
    } cfg_t;

    typedef struct packed {
        logic [NUM_ROWS-1:0] row_drive;
        event_t              key_event;
        logic [ROW_BITS-1:0] event_row;
        logic [COL_BITS-1:0] event_column;
    } result_t;

endpackage

// ===== sv/matrix_keypad_debounce_scanner_unit.sv =====
// Keypad scanner for a 4x4 matrix: each transfer on the input channel is one tick's
// column sample, and each produces exactly one transfer on the output channel with the
// row drive and an optional press, release or long-press event. A sample is held in an
// input register, the tick step runs as one pass of logic against the tracking state,
// and the result lands in an output register; a new sample is taken every clock as long
// as the output side keeps taking results, and the tracker's state update on each
// tick sets that rate. Timing registers are in ticks, not clocks.
module matrix_keypad_debounce_scanner_unit
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [mkds_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mkds_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [mkds_pkg::NUM_COLUMNS-1:0]        column_levels,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [mkds_pkg::NUM_ROWS-1:0]           row_drive,
    output logic [1:0]                              key_event,
    output logic [mkds_pkg::ROW_BITS-1:0]           event_row,
    output logic [mkds_pkg::COL_BITS-1:0]           event_column
);

    mkds_pkg::cfg_t                         cfg;
    mkds_pkg::result_t                      step_result;
    mkds_pkg::result_t                      result_reg;
    logic                                   in_valid_reg;
    logic [mkds_pkg::NUM_COLUMNS-1:0]       columns_reg;
    logic                                   out_valid_reg;
    logic                                   advance;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    mkds_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mkds_tracker u_tracker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (in_valid_reg && advance),
        .columns (columns_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            columns_reg <= column_levels;
        end
        if (in_valid_reg && advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_drive    = result_reg.row_drive;
    assign key_event    = 2'(result_reg.key_event);
    assign event_row    = result_reg.event_row;
    assign event_column = result_reg.event_column;

`ifndef NO_ASSERTIONS
    a_row_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(row_drive))
        else $error("row drive has more than one row high");

    a_no_event_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_event == 2'(mkds_pkg::EV_NONE))
            |-> (event_row == '0 && event_column == '0))
        else $error("key position given without an event");

    a_held_sample_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(columns_reg)))
        else $error("stalled sample dropped or changed");

    a_event_not_with_drive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && row_drive != '0) |-> (key_event != 2'(mkds_pkg::EV_PRESS)
            && key_event != 2'(mkds_pkg::EV_RELEASE)))
        else $error("press or release given during a row scan");
`endif

endmodule

// ===== sv/mkds_cfg.sv =====
module mkds_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mkds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mkds_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mkds_pkg::cfg_t                     cfg
);

    mkds_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks       <= mkds_pkg::DEBOUNCE_TICKS_RESET;
            cfg_reg.long_press_ticks     <= mkds_pkg::LONG_PRESS_TICKS_RESET;
            cfg_reg.press_event_enable   <= 1'b0;
            cfg_reg.release_event_enable <= 1'b0;
            cfg_reg.long_event_enable    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mkds_pkg::REG_DEBOUNCE_TICKS:   cfg_reg.debounce_ticks       <= cfg_data;
                mkds_pkg::REG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks     <= cfg_data;
                mkds_pkg::REG_PRESS_EVENT_EN:   cfg_reg.press_event_enable   <= cfg_data[0];
                mkds_pkg::REG_RELEASE_EVENT_EN: cfg_reg.release_event_enable <= cfg_data[0];
                mkds_pkg::REG_LONG_EVENT_EN:    cfg_reg.long_event_enable    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/mkds_tracker.sv =====
module mkds_tracker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick,
    input  logic [mkds_pkg::NUM_COLUMNS-1:0]    columns,
    input  mkds_pkg::cfg_t                      cfg,
    output mkds_pkg::result_t                   result
);

    typedef enum logic [2:0] {
        PH_RELEASED         = 3'd0,
        PH_PRESS_BOUNCING   = 3'd1,
        PH_PRESSED          = 3'd2,
        PH_LONG_PRESSED     = 3'd3,
        PH_RELEASE_BOUNCING = 3'd4
    } phase_t;

    localparam int TB = mkds_pkg::TIMER_BITS;
    localparam int RB = mkds_pkg::ROW_BITS;
    localparam int CB = mkds_pkg::COL_BITS;
    localparam int NC = mkds_pkg::NUM_COLUMNS;
    localparam int NR = mkds_pkg::NUM_ROWS;
    localparam logic [RB-1:0] LAST_ROW = RB'(mkds_pkg::NUM_ROWS - 1);

    phase_t         phase_reg, phase_next, phase_mid;
    logic [TB-1:0]  debounce_count_reg, debounce_count_next;
    logic [TB-1:0]  hold_count_reg, hold_count_next;
    logic           hold_running_reg, hold_running_next;
    logic [RB-1:0]  scan_row_reg, scan_row_next;
    logic [CB-1:0]  test_col_reg, test_col_next;
    logic [RB-1:0]  held_row_reg, held_row_next;
    logic [CB-1:0]  held_col_reg, held_col_next;
    logic [NC-1:0]  prev_cols_reg;

    logic [NC-1:0]  falls;
    logic [NC-1:0]  rises;
    logic [CB-1:0]  low_fall;
    logic [TB-1:0]  deb;
    logic [TB-1:0]  long_limit;
    logic [TB-1:0]  hold_inc;
    logic [TB-1:0]  debounce_inc;

    assign falls = prev_cols_reg & ~columns;
    assign rises = ~prev_cols_reg & columns;
    assign deb = (TB'(cfg.debounce_ticks) == '0) ? mkds_pkg::TIMER_ONE
                                                 : TB'(cfg.debounce_ticks);
    assign long_limit = (TB'(cfg.long_press_ticks) == '0) ? mkds_pkg::TIMER_ONE
                                                          : TB'(cfg.long_press_ticks);
    assign hold_inc = (hold_count_reg == mkds_pkg::TIMER_MAX) ? mkds_pkg::TIMER_MAX
                                                              : hold_count_reg + 1'b1;
    assign debounce_inc = (debounce_count_reg == mkds_pkg::TIMER_MAX) ? mkds_pkg::TIMER_MAX
                                                                      : debounce_count_reg + 1'b1;

    always_comb
    begin
        low_fall = '0;
        for (int c = NC - 1; c >= 0; c--)
        begin
            if (falls[c])
            begin
                low_fall = CB'(c);
            end
        end
    end

    always_comb
    begin
        phase_mid           = phase_reg;
        debounce_count_next = debounce_count_reg;
        hold_count_next     = hold_count_reg;
        hold_running_next   = hold_running_reg;
        scan_row_next       = scan_row_reg;
        test_col_next       = test_col_reg;
        held_row_next       = held_row_reg;
        held_col_next       = held_col_reg;
        result              = '0;
        result.key_event    = mkds_pkg::EV_NONE;

        if (hold_running_reg)
        begin
            hold_count_next = hold_inc;
            if (hold_inc >= long_limit)
            begin
                hold_running_next = 1'b0;
                if (phase_reg == PH_PRESSED)
                begin
                    phase_mid = PH_LONG_PRESSED;
                    if (cfg.long_event_enable)
                    begin
                        result.key_event    = mkds_pkg::EV_LONG;
                        result.event_row    = held_row_reg;
                        result.event_column = held_col_reg;
                    end
                end
            end
        end

        phase_next = phase_mid;

        unique case (phase_mid) inside
            PH_RELEASED:
            begin
                if (falls != '0)
                begin
                    test_col_next       = low_fall;
                    phase_next          = PH_PRESS_BOUNCING;
                    debounce_count_next = '0;
                    scan_row_next       = '0;
                end
            end
            PH_PRESS_BOUNCING:
            begin
                if (debounce_count_reg < deb)
                begin
                    debounce_count_next = debounce_inc;
                    if (debounce_inc >= deb)
                    begin
                        result.row_drive = NR'(1) << scan_row_reg;
                    end
                end
                else if (columns[test_col_reg])
                begin
                    phase_next        = PH_PRESSED;
                    held_row_next     = scan_row_reg;
                    held_col_next     = test_col_reg;
                    hold_count_next   = '0;
                    hold_running_next = 1'b1;
                    if (cfg.press_event_enable)
                    begin
                        result.key_event    = mkds_pkg::EV_PRESS;
                        result.event_row    = scan_row_reg;
                        result.event_column = test_col_reg;
                    end
                end
                else if (scan_row_reg == LAST_ROW)
                begin
                    phase_next = PH_RELEASED;
                end
                else
                begin
                    scan_row_next    = scan_row_reg + 1'b1;
                    result.row_drive = NR'(1) << (scan_row_reg + 1'b1);
                end
            end
            PH_PRESSED, PH_LONG_PRESSED:
            begin
                if (rises != '0)
                begin
                    phase_next          = PH_RELEASE_BOUNCING;
                    debounce_count_next = '0;
                end
            end
            PH_RELEASE_BOUNCING:
            begin
                if (debounce_count_reg < deb)
                begin
                    debounce_count_next = debounce_inc;
                end
                else if (!columns[held_col_reg])
                begin
                    phase_next = PH_PRESSED;
                end
                else
                begin
                    phase_next        = PH_RELEASED;
                    hold_running_next = 1'b0;
                    if (cfg.release_event_enable)
                    begin
                        result.key_event    = mkds_pkg::EV_RELEASE;
                        result.event_row    = held_row_reg;
                        result.event_column = held_col_reg;
                    end
                end
            end
            default:
            begin
                phase_next = PH_RELEASED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_RELEASED;
            debounce_count_reg <= '0;
            hold_count_reg     <= '0;
            hold_running_reg   <= 1'b0;
            scan_row_reg       <= '0;
            test_col_reg       <= '0;
            held_row_reg       <= '0;
            held_col_reg       <= '0;
            prev_cols_reg      <= '1;
        end
        else if (tick)
        begin
            phase_reg          <= phase_next;
            debounce_count_reg <= debounce_count_next;
            hold_count_reg     <= hold_count_next;
            hold_running_reg   <= hold_running_next;
            scan_row_reg       <= scan_row_next;
            test_col_reg       <= test_col_next;
            held_row_reg       <= held_row_next;
            held_col_reg       <= held_col_next;
            prev_cols_reg      <= columns;
        end
    end

endmodule
